// ----- rtl/cbrg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbrg_pkg
// Types and codes shared by the clipped blit row generator modules.
// ----------------------------------------------------------------------------
package cbrg_pkg;

    // saturated surface dimension, up to MAX_DIM
    localparam int DIM_W   = 13;
    localparam int OFS_W   = 22;
    localparam int FIELD_W = 12;
    localparam int COORD_W = 15;

    typedef logic signed [COORD_W-1:0] coord_t;

    // item kind on the input stream
    typedef enum logic {
        OP_START = 1'b0,
        OP_NEXT  = 1'b1
    } op_t;

    // result kind on the output stream
    typedef enum logic [1:0] {
        ST_STARTED  = 2'd0,
        ST_REJECTED = 2'd1,
        ST_ROW      = 2'd2,
        ST_IDLE     = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SRC_WIDTH   = 3'd0,
        REG_SRC_HEIGHT  = 3'd1,
        REG_DST_WIDTH   = 3'd2,
        REG_DST_HEIGHT  = 3'd3,
        REG_CLIP_LEFT   = 3'd4,
        REG_CLIP_TOP    = 3'd5,
        REG_CLIP_WIDTH  = 3'd6,
        REG_CLIP_HEIGHT = 3'd7
    } reg_idx_t;

    // configuration as seen by the datapath, surface sizes already saturated
    typedef struct packed {
        logic [DIM_W-1:0]   src_w;
        logic [DIM_W-1:0]   src_h;
        logic [DIM_W-1:0]   dst_w;
        logic [DIM_W-1:0]   dst_h;
        logic [10:0]        clip_left;
        logic [10:0]        clip_top;
        logic [FIELD_W-1:0] clip_width;
        logic [FIELD_W-1:0] clip_height;
    } cfg_t;

    // one input item
    typedef struct packed {
        op_t                op;
        logic               has_src_rect;
        logic [FIELD_W-1:0] src_left;
        logic [FIELD_W-1:0] src_top;
        logic [FIELD_W-1:0] src_span_w;
        logic [FIELD_W-1:0] src_span_h;
        logic               has_dst_pos;
        logic [FIELD_W-1:0] dst_left;
        logic [FIELD_W-1:0] dst_top;
    } in_item_t;

    // outcome of a start command
    typedef struct packed {
        logic             ok;
        logic [OFS_W-1:0] src_ofs;
        logic [OFS_W-1:0] dst_ofs;
        logic [DIM_W-1:0] copy_w;
        logic [DIM_W-1:0] copy_h;
    } start_res_t;

endpackage : cbrg_pkg
`default_nettype wire

// ----- rtl/cbrg_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbrg_cfg_regs
// Configuration register file with surface size saturation.
// ----------------------------------------------------------------------------
module cbrg_cfg_regs
    import cbrg_pkg::*;
#(
    parameter int MAX_DIM = 2048
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [FIELD_W-1:0] cfg_data,
    output cfg_t                    cfg
);

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    logic [FIELD_W-1:0] src_width_reg;
    logic [FIELD_W-1:0] src_height_reg;
    logic [FIELD_W-1:0] dst_width_reg;
    logic [FIELD_W-1:0] dst_height_reg;
    logic [10:0]        clip_left_reg;
    logic [10:0]        clip_top_reg;
    logic [FIELD_W-1:0] clip_width_reg;
    logic [FIELD_W-1:0] clip_height_reg;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [FIELD_W-1:0] v);
        logic [DIM_W-1:0] wide;
        wide = {1'b0, v};
        return (wide > MAX_DIM_V) ? MAX_DIM_V : wide;
    endfunction

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= 12'd320;
            src_height_reg  <= 12'd200;
            dst_width_reg   <= 12'd320;
            dst_height_reg  <= 12'd200;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_width_reg  <= '0;
            clip_height_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SRC_WIDTH:   src_width_reg   <= cfg_data;
                REG_SRC_HEIGHT:  src_height_reg  <= cfg_data;
                REG_DST_WIDTH:   dst_width_reg   <= cfg_data;
                REG_DST_HEIGHT:  dst_height_reg  <= cfg_data;
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_data[10:0];
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data[10:0];
                REG_CLIP_WIDTH:  clip_width_reg  <= cfg_data;
                REG_CLIP_HEIGHT: clip_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturated view for the datapath
    always_comb
    begin
        cfg.src_w       = sat_dim(src_width_reg);
        cfg.src_h       = sat_dim(src_height_reg);
        cfg.dst_w       = sat_dim(dst_width_reg);
        cfg.dst_h       = sat_dim(dst_height_reg);
        cfg.clip_left   = clip_left_reg;
        cfg.clip_top    = clip_top_reg;
        cfg.clip_width  = clip_width_reg;
        cfg.clip_height = clip_height_reg;
    end

endmodule : cbrg_cfg_regs
`default_nettype wire

// ----- rtl/cbrg_start_calc.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbrg_start_calc
// Clips a start command against source surface and destination clip, and
// computes the copy size and the first row offsets.
// ----------------------------------------------------------------------------
module cbrg_start_calc
    import cbrg_pkg::*;
(
    input  wire cfg_t     cfg,
    input  wire in_item_t item,
    output start_res_t    res
);

    function automatic coord_t cmax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic coord_t cmin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t sx12(input logic [FIELD_W-1:0] v);
        return {{(COORD_W-FIELD_W){v[FIELD_W-1]}}, v};
    endfunction

    function automatic coord_t ux(input logic [DIM_W-1:0] v);
        return {{(COORD_W-DIM_W){1'b0}}, v};
    endfunction

    coord_t sw, sh, dw, dh;
    coord_t rx, ry, s_r, s_b;
    coord_t s_x, s_y, s_w, s_h;
    coord_t c_x, c_y, c_w, c_h;
    coord_t tx, ty, d_r, d_b;
    coord_t d_x, d_y, d_w, d_h;
    coord_t cw, ch;
    logic   src_ok, dst_ok, clip_all_zero;
    logic [24:0] src_prod, dst_prod;

    always_comb
    begin
        sw = ux(cfg.src_w);
        sh = ux(cfg.src_h);
        dw = ux(cfg.dst_w);
        dh = ux(cfg.dst_h);

        // source rectangle against source surface
        rx  = sx12(item.src_left);
        ry  = sx12(item.src_top);
        s_r = cmin(rx + ux({1'b0, item.src_span_w}), sw);
        s_b = cmin(ry + ux({1'b0, item.src_span_h}), sh);
        if (item.has_src_rect)
        begin
            s_x    = cmax(rx, '0);
            s_y    = cmax(ry, '0);
            src_ok = (s_r > s_x) && (s_b > s_y);
            s_w    = s_r - s_x;
            s_h    = s_b - s_y;
        end
        else
        begin
            s_x    = '0;
            s_y    = '0;
            src_ok = 1'b1;
            s_w    = sw;
            s_h    = sh;
        end

        // destination clip, clamped to the surface
        clip_all_zero = (cfg.clip_left == '0) && (cfg.clip_top == '0)
                     && (cfg.clip_width == '0) && (cfg.clip_height == '0);
        if (clip_all_zero)
        begin
            c_x = '0;
            c_y = '0;
            c_w = dw;
            c_h = dh;
        end
        else
        begin
            c_x = cmin(ux({2'b00, cfg.clip_left}), dw);
            c_y = cmin(ux({2'b00, cfg.clip_top}), dh);
            c_w = cmin(ux({2'b00, cfg.clip_left}) + ux({1'b0, cfg.clip_width}), dw) - c_x;
            c_h = cmin(ux({2'b00, cfg.clip_top}) + ux({1'b0, cfg.clip_height}), dh) - c_y;
        end

        // destination position against clip, sized by clipped source
        tx  = sx12(item.dst_left);
        ty  = sx12(item.dst_top);
        d_r = cmin(tx + s_w, c_x + c_w);
        d_b = cmin(ty + s_h, c_y + c_h);
        if (item.has_dst_pos)
        begin
            d_x    = cmax(tx, c_x);
            d_y    = cmax(ty, c_y);
            dst_ok = (d_r > d_x) && (d_b > d_y);
            d_w    = d_r - d_x;
            d_h    = d_b - d_y;
        end
        else
        begin
            d_x    = c_x;
            d_y    = c_y;
            dst_ok = 1'b1;
            d_w    = c_w;
            d_h    = c_h;
        end

        cw = cmin(s_w, d_w);
        ch = cmin(s_h, d_h);

        // first row offsets, wrapped to the offset width
        src_prod = s_y[FIELD_W-1:0] * cfg.src_w;
        dst_prod = d_y[FIELD_W-1:0] * cfg.dst_w;

        res.ok      = src_ok && dst_ok;
        res.src_ofs = src_prod[OFS_W-1:0] + OFS_W'(s_x[FIELD_W-1:0]);
        res.dst_ofs = dst_prod[OFS_W-1:0] + OFS_W'(d_x[FIELD_W-1:0]);
        res.copy_w  = cw[DIM_W-1:0];
        res.copy_h  = ch[DIM_W-1:0];
    end

endmodule : cbrg_start_calc
`default_nettype wire

// ----- rtl/clipped_blit_row_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_blit_row_generator
// Row address generator of an 8-bit-per-pixel blitter with clipping.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The block takes an item every
// cycle unless a result held on the row stream stalls it; each result passes
// through the input register and then the result register, with the clip and
// first row address math of a start command done combinationally between them.
// A start command (tuser op 0) clips the source rectangle and destination
// position, reports the copy width and row count, and arms the row sequence;
// each next request (tuser op 1) returns one row with its source and
// destination byte offsets, tlast marking the final row. Surface sizes above
// MAX_DIM are saturated. Configuration writes are taken at any time, but must
// only be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module clipped_blit_row_generator
    import cbrg_pkg::*;
#(
    parameter int MAX_DIM = 2048
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [FIELD_W-1:0] cfg_data,

    // command stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // src_left, src_top, src_span_w, src_span_h, dst_left, dst_top
    input  wire logic [71:0]        s_axis_tdata,
    // op, has_src_rect, has_dst_pos
    input  wire logic [2:0]         s_axis_tuser,

    // row stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // src_offset, dst_offset, row_bytes, row_total, zero pad
    output logic [71:0]             m_axis_tdata,
    // status
    output logic [1:0]              m_axis_tuser,
    output logic                    m_axis_tlast
);

    cfg_t       cfg;
    start_res_t start_res;

    logic     in_valid_reg;
    in_item_t in_item_reg;

    logic               out_valid_reg;
    status_t            out_status_reg, out_status_next;
    logic [OFS_W-1:0]   out_src_ofs_reg, out_src_ofs_next;
    logic [OFS_W-1:0]   out_dst_ofs_reg, out_dst_ofs_next;
    logic [FIELD_W-1:0] out_row_bytes_reg, out_row_bytes_next;
    logic [FIELD_W-1:0] out_row_total_reg, out_row_total_next;
    logic               out_last_reg, out_last_next;

    logic               active_reg, active_next;
    logic [OFS_W-1:0]   src_row_reg, src_row_next;
    logic [OFS_W-1:0]   dst_row_reg, dst_row_next;
    logic [DIM_W-1:0]   rows_left_reg, rows_left_next;
    logic [FIELD_W-1:0] copy_bytes_reg, copy_bytes_next;

    logic advance;
    logic fire;

    cbrg_cfg_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbrg_start_calc u_start_calc (
        .cfg  (cfg),
        .item (in_item_reg),
        .res  (start_res)
    );

    // handshake: result register frees up when empty or taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.op           <= op_t'(s_axis_tuser[0]);
            in_item_reg.has_src_rect <= s_axis_tuser[1];
            in_item_reg.has_dst_pos  <= s_axis_tuser[2];
            in_item_reg.src_left     <= s_axis_tdata[11:0];
            in_item_reg.src_top      <= s_axis_tdata[23:12];
            in_item_reg.src_span_w   <= s_axis_tdata[35:24];
            in_item_reg.src_span_h   <= s_axis_tdata[47:36];
            in_item_reg.dst_left     <= s_axis_tdata[59:48];
            in_item_reg.dst_top      <= s_axis_tdata[71:60];
        end
    end

    // result and blit state for the item in the input register
    always_comb
    begin
        out_status_next    = ST_IDLE;
        out_src_ofs_next   = '0;
        out_dst_ofs_next   = '0;
        out_row_bytes_next = '0;
        out_row_total_next = '0;
        out_last_next      = 1'b0;
        active_next        = active_reg;
        src_row_next       = src_row_reg;
        dst_row_next       = dst_row_reg;
        rows_left_next     = rows_left_reg;
        copy_bytes_next    = copy_bytes_reg;

        if (in_item_reg.op == OP_START)
        begin
            if (!start_res.ok)
            begin
                out_status_next = ST_REJECTED;
                active_next     = 1'b0;
            end
            else
            begin
                out_status_next    = ST_STARTED;
                out_src_ofs_next   = start_res.src_ofs;
                out_dst_ofs_next   = start_res.dst_ofs;
                out_row_bytes_next = start_res.copy_w[FIELD_W-1:0];
                out_row_total_next = start_res.copy_h[FIELD_W-1:0];
                active_next        = (start_res.copy_h != '0);
                src_row_next       = start_res.src_ofs;
                dst_row_next       = start_res.dst_ofs;
                rows_left_next     = start_res.copy_h;
                copy_bytes_next    = start_res.copy_w[FIELD_W-1:0];
            end
        end
        else if (active_reg)
        begin
            // emit one row and step to the next
            out_status_next    = ST_ROW;
            out_src_ofs_next   = src_row_reg;
            out_dst_ofs_next   = dst_row_reg;
            out_row_bytes_next = copy_bytes_reg;
            out_last_next      = (rows_left_reg == DIM_W'(1));
            src_row_next       = src_row_reg + OFS_W'(cfg.src_w);
            dst_row_next       = dst_row_reg + OFS_W'(cfg.dst_w);
            rows_left_next     = rows_left_reg - DIM_W'(1);
            active_next        = (rows_left_reg != DIM_W'(1));
        end
    end

    // blit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            src_row_reg    <= '0;
            dst_row_reg    <= '0;
            rows_left_reg  <= '0;
            copy_bytes_reg <= '0;
        end
        else if (fire)
        begin
            active_reg     <= active_next;
            src_row_reg    <= src_row_next;
            dst_row_reg    <= dst_row_next;
            rows_left_reg  <= rows_left_next;
            copy_bytes_reg <= copy_bytes_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg    <= out_status_next;
            out_src_ofs_reg   <= out_src_ofs_next;
            out_dst_ofs_reg   <= out_dst_ofs_next;
            out_row_bytes_reg <= out_row_bytes_next;
            out_row_total_reg <= out_row_total_next;
            out_last_reg      <= out_last_next;
        end
    end

    // output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'b0000, out_row_total_reg, out_row_bytes_reg,
                            out_dst_ofs_reg, out_src_ofs_reg};

endmodule : clipped_blit_row_generator
`default_nettype wire

// ----- tb/clipped_blit_row_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_blit_row_generator_tb
// Self-checking bench for the clipped blit row generator. Start commands and
// row requests go in on the command stream. A behavioral model of the clip
// and row stepping predicts every result, and each result on the row stream
// is compared field by field with the oldest prediction. Directed cases cover
// the reset settings, rejected and empty starts, zero-width copies and pitch
// changes in the middle of a blit. Then random blits run under many register
// settings with random gaps on both streams, a long hold on the output and a
// full drain of the sender.
// ----------------------------------------------------------------------------
module clipped_blit_row_generator_tb;
    import cbrg_pkg::*;

    localparam int MAX_DIM     = 2048;
    localparam int LONG_HOLD   = 300;
    localparam int ITEM_TARGET = 1500;

    typedef logic [7:0][FIELD_W-1:0] reg_set_t;

    // one result as the row stream carries it
    typedef struct packed {
        status_t            status;
        logic [OFS_W-1:0]   src_ofs;
        logic [OFS_W-1:0]   dst_ofs;
        logic [FIELD_W-1:0] row_bytes;
        logic [FIELD_W-1:0] row_total;
        logic               last;
    } row_result_t;

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } rect_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = '0;
    logic [11:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // register copy and blit state of the behavioral model
    reg_set_t         reg_shadow;
    logic             blit_live   = 1'b0;
    logic [OFS_W-1:0] src_row_ofs = '0;
    logic [OFS_W-1:0] dst_row_ofs = '0;
    int               rows_todo   = 0;
    logic [11:0]      blit_bytes  = '0;

    row_result_t blit_results_due[$];
    int          error_count  = 0;
    int          items_issued = 0;
    bit          gaps_on      = 1'b1;
    int          hold_asked   = 0;
    int          hold_served;
    int          rx_hold;
    int          rx_stall;

    clipped_blit_row_generator #(
        .MAX_DIM (MAX_DIM)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // behavioral model
    // ------------------------------------------------------------------------

    function automatic int sat_dim(input logic [11:0] v);
        return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic int min_int(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // intersection of two rectangles, false when empty
    function automatic bit overlap(input rect_t a, input rect_t b, output rect_t r);
        int l;
        int t;
        int rt;
        int bt;
        l  = (a.x > b.x) ? a.x : b.x;
        t  = (a.y > b.y) ? a.y : b.y;
        rt = min_int(a.x + a.w, b.x + b.w);
        bt = min_int(a.y + a.h, b.y + b.h);
        r  = '{l, t, rt - l, bt - t};
        return (rt > l) && (bt > t);
    endfunction

    function automatic row_result_t predict_blit_result(input in_item_t it);
        row_result_t res;
        rect_t       sr;
        rect_t       dr;
        rect_t       req;
        int          sw;
        int          sh;
        int          dw;
        int          dh;
        int          cl;
        int          ct;
        int          cw;
        int          ch;
        sw  = sat_dim(reg_shadow[REG_SRC_WIDTH]);
        sh  = sat_dim(reg_shadow[REG_SRC_HEIGHT]);
        dw  = sat_dim(reg_shadow[REG_DST_WIDTH]);
        dh  = sat_dim(reg_shadow[REG_DST_HEIGHT]);
        res = '0;
        if (it.op == OP_START) begin
            blit_live = 1'b0;
            sr = '{0, 0, sw, sh};
            // optional source rectangle against the source surface
            if (it.has_src_rect) begin
                req = '{int'($signed(it.src_left)), int'($signed(it.src_top)),
                        int'(it.src_span_w), int'(it.src_span_h)};
                if (!overlap(req, sr, sr)) begin
                    res.status = ST_REJECTED;
                    return res;
                end
            end
            // clip window, whole surface when every clip register is zero
            if (reg_shadow[REG_CLIP_LEFT] == '0 && reg_shadow[REG_CLIP_TOP] == '0 &&
                reg_shadow[REG_CLIP_WIDTH] == '0 && reg_shadow[REG_CLIP_HEIGHT] == '0) begin
                dr = '{0, 0, dw, dh};
            end else begin
                cl   = int'(reg_shadow[REG_CLIP_LEFT]);
                ct   = int'(reg_shadow[REG_CLIP_TOP]);
                dr.x = min_int(cl, dw);
                dr.y = min_int(ct, dh);
                dr.w = min_int(cl + int'(reg_shadow[REG_CLIP_WIDTH]), dw) - dr.x;
                dr.h = min_int(ct + int'(reg_shadow[REG_CLIP_HEIGHT]), dh) - dr.y;
            end
            // optional destination position, sized by the clipped source
            if (it.has_dst_pos) begin
                req = '{int'($signed(it.dst_left)), int'($signed(it.dst_top)), sr.w, sr.h};
                if (!overlap(req, dr, dr)) begin
                    res.status = ST_REJECTED;
                    return res;
                end
            end
            cw          = min_int(sr.w, dr.w);
            ch          = min_int(sr.h, dr.h);
            src_row_ofs = OFS_W'(sr.y * sw + sr.x);
            dst_row_ofs = OFS_W'(dr.y * dw + dr.x);
            blit_bytes  = 12'(cw);
            rows_todo   = ch;
            blit_live   = (ch > 0);
            res.status    = ST_STARTED;
            res.src_ofs   = src_row_ofs;
            res.dst_ofs   = dst_row_ofs;
            res.row_bytes = blit_bytes;
            res.row_total = 12'(ch);
        end else if (!blit_live) begin
            res.status = ST_IDLE;
        end else begin
            // one row, then step both offsets by the current pitch
            res.status    = ST_ROW;
            res.src_ofs   = src_row_ofs;
            res.dst_ofs   = dst_row_ofs;
            res.row_bytes = blit_bytes;
            res.last      = (rows_todo == 1);
            src_row_ofs   = src_row_ofs + OFS_W'(sw);
            dst_row_ofs   = dst_row_ofs + OFS_W'(dw);
            rows_todo--;
            if (rows_todo == 0) begin
                blit_live = 1'b0;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [11:0] pick_coord(input int extent);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 12'($urandom_range(0, extent + 4));
        end
        if (r < 80) begin
            return 12'(-int'($urandom_range(1, 20)));
        end
        return 12'($urandom());
    endfunction

    function automatic logic [11:0] pick_span(input int extent);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 12'($urandom_range(1, 24));
        end
        if (r < 85) begin
            return 12'($urandom_range(0, extent + 8));
        end
        return 12'($urandom());
    endfunction

    function automatic logic [11:0] random_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return 12'd0;
        end
        if (r < 12) begin
            return 12'd1;
        end
        if (r < 22) begin
            return 12'd2048;
        end
        if (r < 30) begin
            return 12'($urandom_range(2049, 4095));
        end
        if (r < 60) begin
            return 12'($urandom_range(2, 64));
        end
        return 12'($urandom_range(1, 2048));
    endfunction

    function automatic logic [11:0] random_clip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 12'($urandom_range(0, 40));
        end
        if (r < 85) begin
            return 12'($urandom());
        end
        return $urandom_range(0, 1) ? 12'd4095 : 12'd2047;
    endfunction

    // any item, every bit random
    function automatic in_item_t random_item();
        logic [95:0] noise;
        in_item_t    it;
        noise = {$urandom(), $urandom(), $urandom()};
        it    = noise[$bits(in_item_t)-1:0];
        return it;
    endfunction

    function automatic in_item_t make_next();
        in_item_t it;
        it    = random_item();
        it.op = OP_NEXT;
        return it;
    endfunction

    // start command aimed mostly at the current surfaces
    function automatic in_item_t make_start();
        in_item_t it;
        int       sw;
        int       sh;
        int       dw;
        int       dh;
        sw              = sat_dim(reg_shadow[REG_SRC_WIDTH]);
        sh              = sat_dim(reg_shadow[REG_SRC_HEIGHT]);
        dw              = sat_dim(reg_shadow[REG_DST_WIDTH]);
        dh              = sat_dim(reg_shadow[REG_DST_HEIGHT]);
        it              = random_item();
        it.op           = OP_START;
        it.has_src_rect = ($urandom_range(0, 3) != 0);
        it.src_left     = pick_coord(sw);
        it.src_top      = pick_coord(sh);
        it.src_span_w   = pick_span(sw);
        it.src_span_h   = pick_span(sh);
        it.has_dst_pos  = ($urandom_range(0, 3) != 0);
        it.dst_left     = pick_coord(dw);
        it.dst_top      = pick_coord(dh);
        return it;
    endfunction

    function automatic in_item_t start_cmd(input logic has_src, input int sl, input int st,
                                           input int sw, input int sh, input logic has_dst,
                                           input int dl, input int dt);
        in_item_t it;
        it.op           = OP_START;
        it.has_src_rect = has_src;
        it.src_left     = 12'(sl);
        it.src_top      = 12'(st);
        it.src_span_w   = 12'(sw);
        it.src_span_h   = 12'(sh);
        it.has_dst_pos  = has_dst;
        it.dst_left     = 12'(dl);
        it.dst_top      = 12'(dt);
        return it;
    endfunction

    function automatic reg_set_t random_regs(input int phase);
        reg_set_t v;
        v[REG_SRC_WIDTH]  = random_dim();
        v[REG_SRC_HEIGHT] = random_dim();
        v[REG_DST_WIDTH]  = random_dim();
        v[REG_DST_HEIGHT] = random_dim();
        if ($urandom_range(0, 2) == 0) begin
            v[REG_CLIP_LEFT]   = '0;
            v[REG_CLIP_TOP]    = '0;
            v[REG_CLIP_WIDTH]  = '0;
            v[REG_CLIP_HEIGHT] = '0;
        end else begin
            v[REG_CLIP_LEFT]   = random_clip();
            v[REG_CLIP_TOP]    = random_clip();
            v[REG_CLIP_WIDTH]  = random_clip();
            v[REG_CLIP_HEIGHT] = random_clip();
        end
        // largest and smallest settings now and then
        if (phase % 6 == 1) begin
            v[REG_SRC_WIDTH]   = 12'd4095;
            v[REG_SRC_HEIGHT]  = 12'd4095;
            v[REG_DST_WIDTH]   = 12'd4095;
            v[REG_DST_HEIGHT]  = 12'd4095;
            v[REG_CLIP_LEFT]   = 12'd2047;
            v[REG_CLIP_TOP]    = 12'd2047;
            v[REG_CLIP_WIDTH]  = 12'd4095;
            v[REG_CLIP_HEIGHT] = 12'd4095;
        end else if (phase % 6 == 4) begin
            v[REG_SRC_WIDTH]   = 12'd1;
            v[REG_SRC_HEIGHT]  = 12'd1;
            v[REG_DST_WIDTH]   = 12'd1;
            v[REG_DST_HEIGHT]  = 12'd1;
            v[REG_CLIP_LEFT]   = '0;
            v[REG_CLIP_TOP]    = '0;
            v[REG_CLIP_WIDTH]  = '0;
            v[REG_CLIP_HEIGHT] = '0;
        end
        return v;
    endfunction

    // all eight registers, one transaction each, back to back
    task automatic program_regs(input reg_set_t vals);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) begin
                @(posedge clk);
            end
            if (i == REG_CLIP_LEFT || i == REG_CLIP_TOP) begin
                reg_shadow[i] = {1'b0, vals[i][10:0]};
            end else begin
                reg_shadow[i] = vals[i];
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // one command transaction; valid stays up for a following item with no gap
    task automatic send_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.dst_top, it.dst_left, it.src_span_h, it.src_span_w,
                          it.src_top, it.src_left};
        s_axis_tuser  <= {it.has_dst_pos, it.has_src_rect, it.op};
        @(posedge clk);
        while (!s_axis_tready) begin
            @(posedge clk);
        end
        blit_results_due.push_back(predict_blit_result(it));
        items_issued++;
    endtask

    // sender idle until every predicted result has come back
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (blit_results_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // a start followed by its rows, sometimes cut short or run one past the end, now and then one random item instead
    task automatic run_blit_sequence();
        int rows;
        if ($urandom_range(0, 99) < 8) begin
            send_item(random_item());
            return;
        end
        send_item(make_start());
        rows = blit_live ? rows_todo : 0;
        if (rows > 24) begin
            rows = $urandom_range(1, 24);
        end else if ($urandom_range(0, 3) == 0) begin
            rows = rows + 1;
        end
        repeat (rows) send_item(make_next());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset register values, idle request, replacement of an active blit
    task automatic test_defaults_after_reset();
        send_item(make_next());
        send_item(start_cmd(1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_item(make_next());
        send_item(make_next());
        send_item(start_cmd(1'b1, -5, -3, 10, 10, 1'b1, 315, 195));
        repeat (6) send_item(make_next());
        wait_quiet();
    endtask

    // rejected, empty and zero-width starts, clip clamped to the surface
    task automatic test_start_corner_cases();
        reg_set_t v;
        v[REG_SRC_WIDTH]   = 12'd4095;
        v[REG_SRC_HEIGHT]  = 12'd4095;
        v[REG_DST_WIDTH]   = 12'd64;
        v[REG_DST_HEIGHT]  = 12'd32;
        v[REG_CLIP_LEFT]   = 12'd8;
        v[REG_CLIP_TOP]    = 12'd4;
        v[REG_CLIP_WIDTH]  = 12'd0;
        v[REG_CLIP_HEIGHT] = 12'd10;
        program_regs(v);
        // zero copy width with rows
        send_item(start_cmd(1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_item(make_next());
        send_item(make_next());
        // empty source rectangle drops the active blit
        send_item(start_cmd(1'b1, 5, 5, 0, 7, 1'b0, 0, 0));
        send_item(make_next());
        send_item(start_cmd(1'b1, -2048, -2048, 4095, 4095, 1'b1, 2047, 2047));
        // bottom right corner of a saturated source, largest offset
        send_item(start_cmd(1'b1, 2047, 2047, 4095, 4095, 1'b0, 0, 0));
        send_item(make_next());
        send_item(make_next());
        wait_quiet();
        // clip beyond the surface, empty window
        v[REG_SRC_WIDTH]   = 12'd16;
        v[REG_SRC_HEIGHT]  = 12'd16;
        v[REG_CLIP_LEFT]   = 12'd2047;
        v[REG_CLIP_TOP]    = 12'd100;
        v[REG_CLIP_WIDTH]  = 12'd4095;
        v[REG_CLIP_HEIGHT] = 12'd4095;
        program_regs(v);
        send_item(start_cmd(1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_item(make_next());
        send_item(start_cmd(1'b0, 0, 0, 0, 0, 1'b1, 0, 0));
        send_item(make_next());
        wait_quiet();
    endtask

    // surface widths rewritten while a blit is still active
    task automatic test_pitch_change_mid_blit();
        reg_set_t v;
        v[REG_SRC_WIDTH]   = 12'd100;
        v[REG_SRC_HEIGHT]  = 12'd50;
        v[REG_DST_WIDTH]   = 12'd200;
        v[REG_DST_HEIGHT]  = 12'd100;
        v[REG_CLIP_LEFT]   = '0;
        v[REG_CLIP_TOP]    = '0;
        v[REG_CLIP_WIDTH]  = '0;
        v[REG_CLIP_HEIGHT] = '0;
        program_regs(v);
        send_item(start_cmd(1'b1, 10, 5, 20, 20, 1'b1, 7, 3));
        repeat (3) send_item(make_next());
        wait_quiet();
        v[REG_SRC_WIDTH] = 12'd4095;
        v[REG_DST_WIDTH] = 12'd3000;
        program_regs(v);
        while (blit_live) begin
            send_item(make_next());
        end
        send_item(make_next());
        wait_quiet();
    endtask

    // long output hold while commands keep coming with no gaps
    task automatic test_output_backpressure();
        int stop_at;
        gaps_on    = 1'b0;
        hold_asked <= hold_asked + 1;
        stop_at    = items_issued + 80;
        while (items_issued < stop_at) begin
            run_blit_sequence();
        end
        wait_quiet();
        gaps_on = 1'b1;
    endtask

    // sender drains completely in the middle of a run of blits
    task automatic test_sender_pause();
        int stop_at;
        stop_at = items_issued + 30;
        while (items_issued < stop_at) begin
            run_blit_sequence();
        end
        wait_quiet();
        stop_at = items_issued + 30;
        while (items_issued < stop_at) begin
            run_blit_sequence();
        end
        wait_quiet();
    endtask

    // random blits over many register settings
    task automatic test_random_blits();
        int phase;
        int stop_at;
        phase = 0;
        while (items_issued < ITEM_TARGET) begin
            wait_quiet();
            program_regs(random_regs(phase));
            gaps_on = (phase % 3 != 2);
            stop_at = items_issued + 120;
            while (items_issued < stop_at) begin
                run_blit_sequence();
            end
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // output side: ready with random stalls and a requested long hold
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            hold_served   <= 0;
            rx_hold       <= 0;
            rx_stall      <= 0;
        end else if (hold_served != hold_asked) begin
            hold_served   <= hold_asked;
            rx_hold       <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                rx_stall <= pick_gap();
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // each result transaction against the oldest prediction
    always @(posedge clk) begin : check_results
        row_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (blit_results_due.size() == 0) begin
                $error("unexpected result transaction, status %0d", m_axis_tuser);
                error_count++;
            end else begin
                want = blit_results_due.pop_front();
                compare_field("status", 32'(want.status), 32'(m_axis_tuser));
                compare_field("src_offset", 32'(want.src_ofs), 32'(m_axis_tdata[21:0]));
                compare_field("dst_offset", 32'(want.dst_ofs), 32'(m_axis_tdata[43:22]));
                compare_field("row_bytes", 32'(want.row_bytes), 32'(m_axis_tdata[55:44]));
                compare_field("row_total", 32'(want.row_total), 32'(m_axis_tdata[67:56]));
                compare_field("last", 32'(want.last), 32'(m_axis_tlast));
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------------
    initial begin
        reg_shadow[REG_SRC_WIDTH]   = 12'd320;
        reg_shadow[REG_SRC_HEIGHT]  = 12'd200;
        reg_shadow[REG_DST_WIDTH]   = 12'd320;
        reg_shadow[REG_DST_HEIGHT]  = 12'd200;
        reg_shadow[REG_CLIP_LEFT]   = '0;
        reg_shadow[REG_CLIP_TOP]    = '0;
        reg_shadow[REG_CLIP_WIDTH]  = '0;
        reg_shadow[REG_CLIP_HEIGHT] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_after_reset();
        test_start_corner_cases();
        test_pitch_change_mid_blit();
        test_output_backpressure();
        test_sender_pause();
        test_random_blits();

        wait_quiet();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // run time limit
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
